// ===== design/assert_macros.svh =====
// Assertion macros shared by the scanner RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an implication on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/tisu_pkg.sv =====
// Types and constants shared by the template interpolation scanner
`timescale 1ns / 1ps
package tisu_pkg;

  typedef enum logic [2:0] {
    KIND_INDENT = 3'd0,
    KIND_TEXT   = 3'd1,
    KIND_EXPR   = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_END    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_MISSING_CLOSE = 2'd1,
    ERR_OVERFLOW      = 2'd2
  } err_e;

  localparam logic [15:0] CharHash   = 16'h0023;
  localparam logic [15:0] CharOpen   = 16'h007B;
  localparam logic [15:0] CharClose  = 16'h007D;
  localparam logic [15:0] CharDquote = 16'h0022;
  localparam logic [15:0] CharSquote = 16'h0027;
  localparam logic [15:0] CharBslash = 16'h005C;
  localparam logic [15:0] CharSpace  = 16'h0020;
  localparam logic [15:0] CharTab    = 16'h0009;

  typedef struct packed {
    logic [15:0] ch;
    logic        is_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ch_out;
    kind_e       kind;
    err_e        error_code;
    logic        last_of_run;
  } out_item_t;

  // Results of one accepted item: count, then first and second result
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } scan_res_t;

endpackage

// ===== design/tisu_scan.sv =====
// Line scanner: classifies one character per transfer and updates line state
`timescale 1ns / 1ps
module tisu_scan #(
  parameter int MAX_NEST_DEPTH = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tisu_pkg::in_item_t in_data_i,
  output tisu_pkg::scan_res_t res_o
);

  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DW-1:0] MaxDepth = DW'(MAX_NEST_DEPTH);

  typedef enum logic [1:0] {
    PH_INDENT = 2'd0,
    PH_TEXT   = 2'd1,
    PH_EXPR   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        hash_q, hash_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [15:0] quote_q, quote_d;
  logic        esc_q, esc_d;
  logic        ovf_q, ovf_d;

  function automatic tisu_pkg::out_item_t mk(input logic [15:0] c,
                                             input tisu_pkg::kind_e k,
                                             input tisu_pkg::err_e e);
    tisu_pkg::out_item_t it;
    it.ch_out      = c;
    it.kind        = k;
    it.error_code  = e;
    it.last_of_run = 1'b0;
    return it;
  endfunction

  // Classify the item and work out the next line state
  always_comb begin
    logic [15:0] c;
    tisu_pkg::err_e err;
    tisu_pkg::scan_res_t r;
    c       = in_data_i.ch;
    phase_d = phase_q;
    hash_d  = hash_q;
    depth_d = depth_q;
    quote_d = quote_q;
    esc_d   = esc_q;
    ovf_d   = ovf_q;
    r       = '0;
    err     = tisu_pkg::ERR_NONE;
    if (ovf_q) begin
      err = tisu_pkg::ERR_OVERFLOW;
    end else if (phase_q == PH_EXPR) begin
      err = tisu_pkg::ERR_MISSING_CLOSE;
    end

    if (in_data_i.is_end) begin
      // Flush a pending hash, report, and clear for the next line
      if (hash_q) begin
        r.r0 = mk(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
        r.r1 = mk('0, tisu_pkg::KIND_END, err);
        r.n  = 2'd2;
      end else begin
        r.r0 = mk('0, tisu_pkg::KIND_END, err);
        r.n  = 2'd1;
      end
      phase_d = PH_INDENT;
      hash_d  = 1'b0;
      depth_d = '0;
      quote_d = '0;
      esc_d   = 1'b0;
      ovf_d   = 1'b0;
    end else if (phase_q == PH_INDENT &&
                 (c == tisu_pkg::CharSpace || c == tisu_pkg::CharTab)) begin
      r.r0 = mk(c, tisu_pkg::KIND_INDENT, tisu_pkg::ERR_NONE);
      r.n  = 2'd1;
    end else if (phase_q == PH_EXPR) begin
      // Expression: strings, escapes and brace nesting
      r.n  = 2'd1;
      r.r0 = mk(c, tisu_pkg::KIND_EXPR, tisu_pkg::ERR_NONE);
      if (quote_q != '0) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == quote_q) begin
          quote_d = '0;
        end else if (c == tisu_pkg::CharBslash) begin
          esc_d = 1'b1;
        end
      end else if (c == tisu_pkg::CharClose) begin
        if (depth_q == '0) begin
          phase_d = PH_TEXT;
          r.r0    = mk(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
        end else begin
          depth_d = depth_q - DW'(1);
        end
      end else if (c == tisu_pkg::CharOpen) begin
        if (depth_q >= MaxDepth) begin
          ovf_d = 1'b1;
        end else begin
          depth_d = depth_q + DW'(1);
        end
      end else if (c == tisu_pkg::CharDquote || c == tisu_pkg::CharSquote) begin
        quote_d = c;
        esc_d   = 1'b0;
      end
    end else begin
      // Text phase, entered from indent by any non-whitespace character
      phase_d = PH_TEXT;
      if (hash_q) begin
        hash_d = 1'b0;
        r.n    = 2'd2;
        if (c == tisu_pkg::CharHash) begin
          r.r0 = mk(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
          r.r1 = mk(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
        end else if (c == tisu_pkg::CharOpen) begin
          r.r0    = mk(tisu_pkg::CharHash, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
          r.r1    = mk(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
          phase_d = PH_EXPR;
          depth_d = '0;
          quote_d = '0;
          esc_d   = 1'b0;
        end else begin
          r.r0 = mk(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
          r.r1 = mk(c, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
        end
      end else if (c == tisu_pkg::CharHash) begin
        hash_d = 1'b1;
      end else begin
        r.r0 = mk(c, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
        r.n  = 2'd1;
      end
    end

    // Mark the final result of this item
    r.r0.last_of_run = (r.n == 2'd1);
    r.r1.last_of_run = (r.n == 2'd2);
    res_o = r;
  end

  // Hold line state; advance on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INDENT;
      hash_q  <= 1'b0;
      depth_q <= '0;
      quote_q <= '0;
      esc_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hash_q  <= hash_d;
      depth_q <= depth_d;
      quote_q <= quote_d;
      esc_q   <= esc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== design/tisu_outq.sv =====
// Four-entry result queue: takes up to two results per cycle, gives one
`timescale 1ns / 1ps
module tisu_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tisu_pkg::scan_res_t  res_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic [2:0]           level_o,
  output logic                 valid_o,
  output tisu_pkg::out_item_t  data_o
);

  tisu_pkg::out_item_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] n_push;

  assign n_push  = push_i ? res_i.n : 2'd0;
  // Refuse new items unless two free entries remain
  assign full_o  = cnt_q > 3'd2;
  assign level_o = cnt_q;
  assign valid_o = cnt_q != 3'd0;
  assign data_o  = mem_q[rp_q];

  // Write results into the queue
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wp_q] <= res_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wp_q + 2'd1] <= res_i.r1;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + n_push;
      rp_q  <= rp_q + {1'b0, pop_i};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, pop_i};
    end
  end

endmodule

// ===== design/template_interpolation_scanner_unit.sv =====
// Top level of the template interpolation scanner
//
// Input channel: one UTF-16 code unit per transfer (in_data_i.ch), or an end
// marker (in_data_i.is_end) that closes the line. Output channel: classified
// results (indent, text, expression, dropped syntax, end of line), with an
// error code on the end result and last_of_run on the final result of each
// input item. Both channels transfer when valid is high and stall is low.
// An item is classified in the cycle it is accepted and its results are
// written into a four-entry result queue, which registers them for the output.
// Throughput is one item per cycle while the output
// drains one result per cycle; items that produce two results fill the queue
// and in_stall_o rises once fewer than two entries are free.
// An opening hash gives no result until the next item resolves it.
// Reset clears the line state to the indent phase and empties the queue.
// While the receiver stalls, the head result holds on out_data_o and the
// input stalls as soon as the queue is nearly full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module template_interpolation_scanner_unit #(
  parameter int MAX_NEST_DEPTH = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tisu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tisu_pkg::out_item_t out_data_o
);

  logic                accept;
  logic                pop;
  logic [2:0]          level;
  tisu_pkg::scan_res_t res;

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  tisu_scan #(
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .res_o    (res)
  );

  tisu_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .res_i  (res),
    .pop_i  (pop),
    .full_o (in_stall_o),
    .level_o(level),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

  `ASSERT_NEVER(a_queue_overfill, level > 3'd4, "result queue level beyond depth")
  `ASSERT_CLK(a_end_yields, accept && in_data_i.is_end |-> res.n != 2'd0, "end item gave no result")
  `ASSERT_CLK(a_end_visible, accept && in_data_i.is_end |=> out_valid_o, "no result after end transfer")
  `ASSERT_CLK(a_pair_last, accept && res.n == 2'd2 |-> !res.r0.last_of_run && res.r1.last_of_run, "last flag misplaced in result pair")

endmodule

// ===== test/tb_template_interpolation_scanner_unit.sv =====
// Testbench for the template interpolation scanner: directed table, random lines, checker
`timescale 1ns / 1ps
module tb_template_interpolation_scanner_unit;

  localparam int MaxNest     = 255;
  localparam int RandItems   = 570;
  localparam int QuietFrom   = 470;
  localparam int HoldFrom    = 100;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 10;
  localparam int IdleLimit   = 1000;

  typedef enum logic [1:0] {
    LINE_INDENT,
    LINE_TEXT,
    LINE_EXPR
  } line_phase_e;

  // One row of the directed table; typed rows carry their results
  typedef struct packed {
    logic [15:0]         ch;
    logic                is_end;
    logic [8:0]          reps;
    logic                typed;
    logic [1:0]          n_typed;
    tisu_pkg::out_item_t t0;
    tisu_pkg::out_item_t t1;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  tisu_pkg::in_item_t  in_data_i   = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  tisu_pkg::out_item_t out_data_o;

  // Scanner state as the predictor sees it
  line_phase_e line_ph   = LINE_INDENT;
  bit          hash_wait = 1'b0;
  int unsigned depth     = 0;
  logic [15:0] quote_ch  = '0;
  bit          esc_wait  = 1'b0;
  bit          nest_over = 1'b0;

  tisu_pkg::out_item_t step_tags[$];
  tisu_pkg::out_item_t expected_tags[$];
  tisu_pkg::in_item_t  line_items[$];
  row_t                rows[$];

  int mismatches = 0;
  int rand_items = 0;
  bit quiet      = 1'b0;
  bit rx_hold    = 1'b0;

  template_interpolation_scanner_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic tisu_pkg::out_item_t tag_of(logic [15:0] c, tisu_pkg::kind_e k,
                                                  tisu_pkg::err_e e, logic last);
    tisu_pkg::out_item_t t;
    t.ch_out      = c;
    t.kind        = k;
    t.error_code  = e;
    t.last_of_run = last;
    return t;
  endfunction

  function automatic void add_tag(logic [15:0] c, tisu_pkg::kind_e k, tisu_pkg::err_e e);
    step_tags.push_back(tag_of(c, k, e, 1'b0));
  endfunction

  // Work out the tags one item causes and advance the line state
  function automatic void classify_item(tisu_pkg::in_item_t it);
    logic [15:0]         c;
    tisu_pkg::err_e      err;
    tisu_pkg::out_item_t tail;
    c = it.ch;
    step_tags.delete();
    if (it.is_end) begin
      if (hash_wait) add_tag(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
      if (nest_over) err = tisu_pkg::ERR_OVERFLOW;
      else if (line_ph == LINE_EXPR) err = tisu_pkg::ERR_MISSING_CLOSE;
      else err = tisu_pkg::ERR_NONE;
      add_tag(16'h0000, tisu_pkg::KIND_END, err);
      line_ph   = LINE_INDENT;
      hash_wait = 1'b0;
      depth     = 0;
      quote_ch  = '0;
      esc_wait  = 1'b0;
      nest_over = 1'b0;
    end else begin
      if (line_ph == LINE_INDENT) begin
        if (c == tisu_pkg::CharSpace || c == tisu_pkg::CharTab)
          add_tag(c, tisu_pkg::KIND_INDENT, tisu_pkg::ERR_NONE);
        else line_ph = LINE_TEXT;
      end
      if (step_tags.size() == 0 && line_ph == LINE_TEXT) begin
        if (hash_wait) begin
          hash_wait = 1'b0;
          if (c == tisu_pkg::CharHash) begin
            add_tag(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
            add_tag(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
          end else if (c == tisu_pkg::CharOpen) begin
            add_tag(tisu_pkg::CharHash, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
            add_tag(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
            line_ph  = LINE_EXPR;
            depth    = 0;
            quote_ch = '0;
            esc_wait = 1'b0;
          end else begin
            add_tag(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
            add_tag(c, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
          end
        end else if (c == tisu_pkg::CharHash) begin
          hash_wait = 1'b1;
        end else begin
          add_tag(c, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE);
        end
      end else if (step_tags.size() == 0 && line_ph == LINE_EXPR) begin
        // Inside a string only the closing quote and escapes matter
        if (quote_ch != 16'h0000) begin
          if (esc_wait) esc_wait = 1'b0;
          else if (c == quote_ch) quote_ch = '0;
          else if (c == tisu_pkg::CharBslash) esc_wait = 1'b1;
          add_tag(c, tisu_pkg::KIND_EXPR, tisu_pkg::ERR_NONE);
        end else if (c == tisu_pkg::CharClose && depth == 0) begin
          line_ph = LINE_TEXT;
          add_tag(c, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE);
        end else begin
          if (c == tisu_pkg::CharClose) begin
            depth--;
          end else if (c == tisu_pkg::CharOpen) begin
            if (depth >= MaxNest) nest_over = 1'b1;
            else depth++;
          end else if (c == tisu_pkg::CharDquote || c == tisu_pkg::CharSquote) begin
            quote_ch = c;
            esc_wait = 1'b0;
          end
          add_tag(c, tisu_pkg::KIND_EXPR, tisu_pkg::ERR_NONE);
        end
      end
    end
    // Flag the final tag of this item
    if (step_tags.size() > 0) begin
      tail = step_tags.pop_back();
      tail.last_of_run = 1'b1;
      step_tags.push_back(tail);
    end
  endfunction

  function automatic void add_row(logic [15:0] c, logic e = 1'b0, int reps = 1,
                                  logic typed = 1'b0, int n = 0,
                                  tisu_pkg::out_item_t t0 = '0,
                                  tisu_pkg::out_item_t t1 = '0);
    row_t r;
    r.ch      = c;
    r.is_end  = e;
    r.reps    = reps[8:0];
    r.typed   = typed;
    r.n_typed = n[1:0];
    r.t0      = t0;
    r.t1      = t1;
    rows.push_back(r);
  endfunction

  function automatic logic [15:0] any_char();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0020, 16'h007E));
      1: return 16'($urandom_range(0, 16'hFFFF));
      2: begin
        case ($urandom_range(0, 7))
          0: return tisu_pkg::CharHash;
          1: return tisu_pkg::CharOpen;
          2: return tisu_pkg::CharClose;
          3: return tisu_pkg::CharDquote;
          4: return tisu_pkg::CharSquote;
          5: return tisu_pkg::CharBslash;
          6: return tisu_pkg::CharSpace;
          default: return tisu_pkg::CharTab;
        endcase
      end
      default: return 16'(16'h0061 + $urandom_range(0, 25));
    endcase
  endfunction

  // Characters that never touch quote, escape or brace handling
  function automatic logic [15:0] safe_char();
    if ($urandom_range(0, 1)) return 16'(16'h0061 + $urandom_range(0, 25));
    return 16'($urandom_range(16'h0080, 16'hFFFF));
  endfunction

  function automatic void push_item(logic [15:0] c, logic e = 1'b0);
    tisu_pkg::in_item_t it;
    it.ch     = c;
    it.is_end = e;
    line_items.push_back(it);
  endfunction

  // Build one line: indent, then text, hash pairs, expressions and noise
  function automatic void build_line();
    int          nest;
    logic [15:0] q;
    bit          broken;
    line_items.delete();
    broken = ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, 3))
      push_item($urandom_range(0, 1) ? tisu_pkg::CharSpace : tisu_pkg::CharTab);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 4)) push_item(any_char());
        4: begin
          push_item(tisu_pkg::CharHash);
          push_item(tisu_pkg::CharHash);
        end
        5, 6, 7: begin
          push_item(tisu_pkg::CharHash);
          push_item(tisu_pkg::CharOpen);
          nest = 0;
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 4))
              0: begin
                push_item(tisu_pkg::CharOpen);
                nest++;
              end
              1: if (nest > 0) begin
                push_item(tisu_pkg::CharClose);
                nest--;
              end
              2: begin
                q = $urandom_range(0, 1) ? tisu_pkg::CharDquote : tisu_pkg::CharSquote;
                push_item(q);
                repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 3) == 0) begin
                    push_item(tisu_pkg::CharBslash);
                    push_item(any_char());
                  end else begin
                    push_item(safe_char());
                  end
                end
                if (!broken || $urandom_range(0, 1)) push_item(q);
              end
              3: push_item(tisu_pkg::CharBslash);
              default: push_item(safe_char());
            endcase
          end
          if (!broken) begin
            repeat (nest) push_item(tisu_pkg::CharClose);
            push_item(tisu_pkg::CharClose);
          end
        end
        8: begin
          push_item(tisu_pkg::CharHash);
          push_item(any_char());
        end
        default: repeat ($urandom_range(1, 3)) push_item(16'($urandom_range(0, 16'hFFFF)));
      endcase
    end
    push_item(16'($urandom_range(0, 16'hFFFF)), 1'b1);
  endfunction

  // Offer one item, hold it until the transfer, then record its tags
  task automatic send_item(tisu_pkg::in_item_t it, logic typed = 1'b0, int n = 0,
                           tisu_pkg::out_item_t t0 = '0, tisu_pkg::out_item_t t1 = '0);
    if (!quiet && !rx_hold && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    classify_item(it);
    if (typed) begin
      if (n > 0) expected_tags.push_back(t0);
      if (n > 1) expected_tags.push_back(t1);
    end else begin
      foreach (step_tags[i]) expected_tags.push_back(step_tags[i]);
    end
  endtask

  // Stimulus: reset, directed table, then random lines
  initial begin : stimulus
    tisu_pkg::in_item_t it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(tisu_pkg::CharSpace, 1'b0, 1, 1'b1, 1,
            tag_of(tisu_pkg::CharSpace, tisu_pkg::KIND_INDENT, tisu_pkg::ERR_NONE, 1'b1));
    add_row(tisu_pkg::CharTab, 1'b0, 1, 1'b1, 1,
            tag_of(tisu_pkg::CharTab, tisu_pkg::KIND_INDENT, tisu_pkg::ERR_NONE, 1'b1));
    add_row(16'h0061, 1'b0, 1, 1'b1, 1,
            tag_of(16'h0061, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE, 1'b1));
    add_row(tisu_pkg::CharHash, 1'b0, 1, 1'b1, 0);
    add_row(tisu_pkg::CharHash, 1'b0, 1, 1'b1, 2,
            tag_of(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE, 1'b0),
            tag_of(tisu_pkg::CharHash, tisu_pkg::KIND_DROP, tisu_pkg::ERR_NONE, 1'b1));
    add_row(tisu_pkg::CharHash);
    add_row(16'h0062);
    // Expression with strings, an escape, nesting and a bare backslash
    add_row(tisu_pkg::CharHash);
    add_row(tisu_pkg::CharOpen);
    add_row(tisu_pkg::CharDquote);
    add_row(tisu_pkg::CharBslash);
    add_row(tisu_pkg::CharDquote);
    add_row(tisu_pkg::CharClose);
    add_row(tisu_pkg::CharDquote);
    add_row(tisu_pkg::CharSquote);
    add_row(tisu_pkg::CharSquote);
    add_row(tisu_pkg::CharOpen);
    add_row(tisu_pkg::CharClose);
    add_row(tisu_pkg::CharBslash);
    add_row(tisu_pkg::CharClose);
    add_row(tisu_pkg::CharHash);
    add_row(16'hFFFF, 1'b1, 1, 1'b1, 2,
            tag_of(tisu_pkg::CharHash, tisu_pkg::KIND_TEXT, tisu_pkg::ERR_NONE, 1'b0),
            tag_of(16'h0000, tisu_pkg::KIND_END, tisu_pkg::ERR_NONE, 1'b1));
    // Run the nesting past its limit, then open a string that stays open
    add_row(16'h0000);
    add_row(tisu_pkg::CharHash);
    add_row(tisu_pkg::CharOpen);
    add_row(tisu_pkg::CharOpen, 1'b0, 300);
    add_row(tisu_pkg::CharDquote);
    add_row(16'h0000, 1'b1, 1, 1'b1, 1,
            tag_of(16'h0000, tisu_pkg::KIND_END, tisu_pkg::ERR_OVERFLOW, 1'b1));
    add_row(tisu_pkg::CharHash);
    add_row(tisu_pkg::CharOpen);
    add_row(tisu_pkg::CharSquote);
    add_row(16'hFFFF, 1'b1, 1, 1'b1, 1,
            tag_of(16'h0000, tisu_pkg::KIND_END, tisu_pkg::ERR_MISSING_CLOSE, 1'b1));
    add_row(16'h5AA5, 1'b1, 1, 1'b1, 1,
            tag_of(16'h0000, tisu_pkg::KIND_END, tisu_pkg::ERR_NONE, 1'b1));

    foreach (rows[i]) begin
      it.ch     = rows[i].ch;
      it.is_end = rows[i].is_end;
      repeat (rows[i].reps)
        send_item(it, rows[i].typed, rows[i].n_typed, rows[i].t0, rows[i].t1);
    end

    while (rand_items < RandItems) begin
      build_line();
      foreach (line_items[j]) begin
        send_item(line_items[j]);
        rand_items++;
        quiet = (rand_items >= QuietFrom);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow stray ones to show up
    while (expected_tags.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver stalls in bursts, with one long hold while the sender keeps going
  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && rand_items >= HoldFrom) begin
        held        = 1'b1;
        rx_hold     = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold     = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transfer against the oldest expected tag
  always @(posedge clk_i) begin : result_check
    tisu_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected result expected none actual ch %h kind %0d err %0d last %0d",
                 $time, out_data_o.ch_out, out_data_o.kind, out_data_o.error_code,
                 out_data_o.last_of_run);
        mismatches++;
      end else begin
        want = expected_tags.pop_front();
        if (out_data_o.ch_out !== want.ch_out) begin
          $display("%0t: ch_out expected %h actual %h", $time, want.ch_out, out_data_o.ch_out);
          mismatches++;
        end
        if (out_data_o.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data_o.kind);
          mismatches++;
        end
        if (out_data_o.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
                   out_data_o.error_code);
          mismatches++;
        end
        if (out_data_o.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time, want.last_of_run,
                   out_data_o.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Abort when no transfer happens on either side for too long
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
